>>> sv/plsdb_pkg.sv
// Shared types, field widths and defaults of the pulsed level sensor debouncer.
`default_nettype none

package plsdb_pkg;

  // Field widths of the request and result channels
  localparam int CMD_W  = 2;
  localparam int IDX_W  = 8;
  localparam int PIN_W  = 7;
  localparam int EDGE_W = 8;
  localparam int FREQ_W = 16;
  localparam int DUR_W  = 4;

  // Defaults for the top-level parameters
  localparam int LEVEL_CHANNELS_DEF = 7;
  localparam int DEBOUNCE_LEN_DEF   = 5;
  localparam int PULSE_PERIOD_DEF   = 10;

  // Sampling phase used after reset
  localparam logic [DUR_W-1:0] DUR_RESET = 4'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK     = 2'd0,
    CMD_SET_HIGH = 2'd1,
    CMD_SET_LOW  = 2'd2
  } cmd_t;

  // What one debounce lane reports to the merge logic
  typedef struct packed {
    logic state;      // debounced value after this cycle
    logic all_ones;   // history becomes all ones this cycle
    logic all_zeros;  // history becomes all zeros this cycle
  } lane_stat_t;

endpackage

`default_nettype wire

>>> sv/plsdb_lane.sv
// One debounce lane: sample history shift register and debounced state bit.
`default_nettype none

module plsdb_lane #(
  parameter int DEBOUNCE_LEN = plsdb_pkg::DEBOUNCE_LEN_DEF
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     shift_en,
  input  wire                     sample,
  output plsdb_pkg::lane_stat_t   stat
);

  logic [DEBOUNCE_LEN-1:0] hist_r;
  logic [DEBOUNCE_LEN-1:0] hist_nxt;
  logic                    state_r;
  logic                    state_nxt;
  logic                    ones;
  logic                    zeros;

  always_comb begin
    hist_nxt  = hist_r;
    state_nxt = state_r;
    if (shift_en) begin
      hist_nxt = {hist_r[DEBOUNCE_LEN-2:0], sample};
    end
    ones  = &hist_nxt;
    zeros = ~|hist_nxt;
    if (shift_en) begin
      if (ones) begin
        state_nxt = 1'b1;
      end else if (zeros) begin
        state_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r  <= '0;
      state_r <= 1'b0;
    end else begin
      hist_r  <= hist_nxt;
      state_r <= state_nxt;
    end
  end

  assign stat.state     = state_nxt;
  assign stat.all_ones  = shift_en & ones;
  assign stat.all_zeros = shift_en & zeros;

endmodule

`default_nettype wire

>>> sv/pulsed_level_sensor_debouncer_unit.sv
// Top level of the pulsed level sensor debouncer: lanes, merge, latches and edge window.
//
//   channel | signals                                   | handshake
//   --------+-------------------------------------------+-------------
//   request | in_command .. in_flag_value               | in_valid/in_ready
//   result  | out_level_values .. out_frequency         | out_valid/out_ready
//   config  | cfg_wr_data (sampling phase)              | cfg_wr_en, no wait
//
// One request per cycle unless stalled; result visible the cycle after acceptance.
// State and the result register update together, so the result ports read
// the state registers directly; in_ready drops only while a result waits.
// Synchronous active-low reset; the sampling phase resets to 1, low latch to 1.
// A stalled result holds all state but dur_r; phase lookup is one constant table read.
`default_nettype none

module pulsed_level_sensor_debouncer_unit #(
  parameter int LEVEL_CHANNELS = plsdb_pkg::LEVEL_CHANNELS_DEF,
  parameter int DEBOUNCE_LEN   = plsdb_pkg::DEBOUNCE_LEN_DEF,
  parameter int PULSE_PERIOD   = plsdb_pkg::PULSE_PERIOD_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  // request channel
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  [plsdb_pkg::CMD_W-1:0]  in_command,
  input  wire  [plsdb_pkg::IDX_W-1:0]  in_tick_index,
  input  wire  [plsdb_pkg::PIN_W-1:0]  in_level_pins,
  input  wire                          in_input_pin,
  input  wire  [plsdb_pkg::EDGE_W-1:0] in_edge_count,
  input  wire                          in_flag_value,
  // result channel
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [plsdb_pkg::PIN_W-1:0]  out_level_values,
  output logic                         out_input_debounced,
  output logic                         out_input_high_latch,
  output logic                         out_input_low_latch,
  output logic                         out_sensor_power,
  output logic [plsdb_pkg::FREQ_W-1:0] out_frequency,
  // configuration
  input  wire                          cfg_wr_en,
  input  wire  [plsdb_pkg::DUR_W-1:0]  cfg_wr_data
);

  localparam int PH_W      = $clog2(PULSE_PERIOD);
  localparam int IDX_DEPTH = 2 ** plsdb_pkg::IDX_W;

  typedef logic [PH_W-1:0] phase_tbl_t [IDX_DEPTH];

  // tick index -> index mod PULSE_PERIOD, built by counting with wrap
  function automatic phase_tbl_t build_phase_tbl();
    phase_tbl_t tbl;
    int         ph;
    ph = 0;
    for (int i = 0; i < IDX_DEPTH; i++) begin
      tbl[i] = PH_W'(ph);
      ph = (ph == PULSE_PERIOD - 1) ? 0 : ph + 1;
    end
    return tbl;
  endfunction

  localparam phase_tbl_t PHASE_TBL = build_phase_tbl();

  logic [PH_W-1:0]                dur_r;
  logic                           power_r;
  logic                           power_nxt;
  logic                           high_r;
  logic                           high_nxt;
  logic                           low_r;
  logic                           low_nxt;
  logic [plsdb_pkg::FREQ_W-1:0]   acc_r;
  logic [plsdb_pkg::FREQ_W-1:0]   acc_nxt;
  logic [plsdb_pkg::FREQ_W-1:0]   acc_sum;
  logic [plsdb_pkg::FREQ_W-1:0]   freq_r;
  logic [plsdb_pkg::FREQ_W-1:0]   freq_nxt;
  logic [plsdb_pkg::PIN_W-1:0]    levels_r;
  logic [plsdb_pkg::PIN_W-1:0]    levels_nxt;
  logic                           in_state_r;
  logic                           out_valid_r;
  logic                           out_valid_nxt;

  logic                           accept;
  logic                           tick;
  logic [PH_W-1:0]                phase;
  logic                           at_power_on;
  logic                           at_sample;
  logic                           lvl_shift;
  plsdb_pkg::lane_stat_t          in_stat;
  plsdb_pkg::lane_stat_t          lvl_stat [LEVEL_CHANNELS];
  plsdb_pkg::cmd_t                cmd;

  assign in_ready    = !out_valid_r || out_ready;
  assign accept      = in_valid && in_ready;
  assign cmd         = plsdb_pkg::cmd_t'(in_command);
  assign tick        = accept && (cmd == plsdb_pkg::CMD_TICK);
  assign phase       = PHASE_TBL[in_tick_index];
  assign at_power_on = (phase == '0);
  assign at_sample   = !at_power_on && (phase == dur_r);
  assign lvl_shift   = tick && at_sample;

  // Level lanes: shift only at the sampling phase; missing pins read wet
  for (genvar ch = 0; ch < LEVEL_CHANNELS; ch++) begin : g_lvl
    logic wet;
    if (ch < plsdb_pkg::PIN_W) begin : g_pin
      assign wet = ~in_level_pins[ch];
    end else begin : g_nopin
      assign wet = 1'b1;
    end
    plsdb_lane #(
      .DEBOUNCE_LEN (DEBOUNCE_LEN)
    ) u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (lvl_shift),
      .sample   (wet),
      .stat     (lvl_stat[ch])
    );
  end

  // Input lane: shift on every tick
  plsdb_lane #(
    .DEBOUNCE_LEN (DEBOUNCE_LEN)
  ) u_in_lane (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (tick),
    .sample   (~in_input_pin),
    .stat     (in_stat)
  );

  // Merge lane states into the reported level vector
  always_comb begin
    levels_nxt = '0;
    for (int ch = 0; ch < plsdb_pkg::PIN_W; ch++) begin
      if (ch < LEVEL_CHANNELS) begin
        levels_nxt[ch] = lvl_stat[ch].state;
      end
    end
  end

  assign acc_sum = acc_r + plsdb_pkg::FREQ_W'(in_edge_count);

  always_comb begin
    power_nxt     = power_r;
    high_nxt      = high_r;
    low_nxt       = low_r;
    acc_nxt       = acc_r;
    freq_nxt      = freq_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      out_valid_nxt = 1'b1;
      case (cmd)
        plsdb_pkg::CMD_TICK: begin
          if (at_power_on) begin
            power_nxt = 1'b1;
          end else if (at_sample) begin
            power_nxt = 1'b0;
          end
          if (in_stat.all_ones) begin
            high_nxt = 1'b1;
          end else if (in_stat.all_zeros) begin
            low_nxt = 1'b0;
          end
          // tick zero closes the window
          if (in_tick_index == '0) begin
            freq_nxt = acc_sum;
            acc_nxt  = '0;
          end else begin
            acc_nxt  = acc_sum;
          end
        end
        plsdb_pkg::CMD_SET_HIGH: high_nxt = in_flag_value;
        plsdb_pkg::CMD_SET_LOW:  low_nxt  = in_flag_value;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dur_r       <= PH_W'(plsdb_pkg::DUR_RESET);
      power_r     <= 1'b0;
      high_r      <= 1'b0;
      low_r       <= 1'b1;
      acc_r       <= '0;
      freq_r      <= '0;
      levels_r    <= '0;
      in_state_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // saturate the sampling phase into 1 .. PULSE_PERIOD-1
      if (cfg_wr_en) begin
        if (cfg_wr_data == '0) begin
          dur_r <= PH_W'(1);
        end else if (cfg_wr_data > plsdb_pkg::DUR_W'(PULSE_PERIOD - 1)) begin
          dur_r <= PH_W'(PULSE_PERIOD - 1);
        end else begin
          dur_r <= PH_W'(cfg_wr_data);
        end
      end
      power_r     <= power_nxt;
      high_r      <= high_nxt;
      low_r       <= low_nxt;
      acc_r       <= acc_nxt;
      freq_r      <= freq_nxt;
      levels_r    <= levels_nxt;
      in_state_r  <= in_stat.state;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_level_values     = levels_r;
  assign out_input_debounced  = in_state_r;
  assign out_input_high_latch = high_r;
  assign out_input_low_latch  = low_r;
  assign out_sensor_power     = power_r;
  assign out_frequency        = freq_r;

  a_dur_range: assert property (@(posedge clk) disable iff (!rst_n)
    (dur_r != '0) && (dur_r <= PH_W'(PULSE_PERIOD - 1)))
    else $error("sampling phase out of range");

  a_power_on: assert property (@(posedge clk) disable iff (!rst_n)
    tick && at_power_on |=> out_sensor_power)
    else $error("sensor power not raised at phase zero");

  a_levels_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !lvl_shift |=> $stable(out_level_values))
    else $error("level values changed outside a sampling tick");

  a_window: assert property (@(posedge clk) disable iff (!rst_n)
    tick && (in_tick_index == '0) |=> (out_frequency == $past(acc_sum)) && (acc_r == '0))
    else $error("frequency window not closed at tick zero");

endmodule

`default_nettype wire
